/* rtl/core/lpht_pkg.sv */
// shared types and constants of the linear probing hash table
package lpht_pkg;

    localparam int KEY_BYTES = 8;
    localparam int CNT_W     = 9;
    localparam logic [CNT_W-1:0] MAX_FILL_RST = 9'd192;
    localparam logic [63:0] HASH_SEED = 64'd5381;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        MARK_FREE     = 2'd0,
        MARK_OCCUPIED = 2'd1,
        MARK_DELETED  = 2'd2
    } t_mark;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic signed [31:0] new_value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic signed [31:0] found_value;
        logic        status;
    } t_rsp;

    typedef struct packed {
        t_mark       mark;
        logic [3:0]  len;
        logic [63:0] key;
        logic [31:0] value;
    } t_slot;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic mod_step;
        logic rd;
        logic chk;
        logic wr;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic hash_done;
        logic mod_last;
        logic probe_stop;
        logic clr_last;
    } t_sts;

endpackage

/* rtl/core/linear_probe_hash_table.sv */
// top level of the linear probing hash table
//
//  channel   handshake                    payload
//  request   start, busy                  i_req (t_req)
//  result    o_result_valid (strobe)      o_rsp (t_rsp)
//  config    i_cfg_valid, o_cfg_ready     i_cfg_data (max_fill)
//
//  a request hashes the key, reduces the hash to a home slot (a bit select for a
//  power-of-two slot count, else one hash byte per cycle), probes and writes back
//  the probe walk reads and checks one slot of the single-port memory at a time
//  after reset a clearing pass over all TABLE_SLOTS slots keeps busy high
//  the result strobe lasts one cycle; the receiver cannot stall it
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_result_valid,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    lpht_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_rsp      (o_rsp),
        .o_rsp_vld  (o_result_valid)
    );

`ifndef NO_ASSERTIONS
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a request in flight");

    a_refuse_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_rsp.status |-> !o_rsp.hit)
        else $error("refused insert reports a hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_rsp.hit |-> o_rsp.found_value == 32'sd0)
        else $error("miss carries a nonzero value");
`endif

endmodule

/* rtl/core/lpht_ctrl.sv */
// controller state machine of the hash table
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_HASH = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_CHK  = 7'b0100000,
        S_WR   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (i_sts.hash_done) begin
                    n_state = S_MOD;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.probe_stop ? S_WR : S_RD;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* rtl/core/lpht_dp.sv */
// datapath of the hash table: hash, slot reduction, probe walk and slot memory
module lpht_dp
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    output t_sts             o_sts,
    output t_rsp             o_rsp,
    output logic             o_rsp_vld
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = (TABLE_SLOTS == (1 << AW));
    localparam int XW = AW + 8;
    localparam int QW = 10;
    localparam logic [QW-1:0] RECIP = QW'((1 << XW) / TABLE_SLOTS);
    localparam logic [XW-1:0] N_X   = XW'(TABLE_SLOTS);
    localparam logic [AW-1:0] LAST  = AW'(TABLE_SLOTS - 1);

    t_slot mem [TABLE_SLOTS];
    t_slot r_rd;

    logic [1:0]       r_action;
    logic [63:0]      r_key;
    logic [3:0]       r_len;
    logic [31:0]      r_val;
    logic [63:0]      r_h;
    logic [3:0]       r_bi;
    logic [AW-1:0]    r_rem;
    logic [5:0]       r_mbit;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_n;
    logic             r_ff_ok;
    logic [AW-1:0]    r_ff;
    logic             r_hit;
    logic [AW-1:0]    r_pos;
    logic [31:0]      r_found;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_max_fill;
    logic [AW-1:0]    r_clr;
    t_rsp             r_rsp;
    logic             r_rsp_vld;

    logic [3:0]       len_c;
    logic [63:0]      key_m;
    logic [XW-1:0]    dx;
    logic [XW+QW-1:0] dprod;
    logic [QW-1:0]    dq;
    logic [XW+QW-1:0] dqn;
    logic [XW-1:0]    dr;
    logic [AW-1:0]    rem_n;
    logic             occ, match;
    logic             we;
    logic [AW-1:0]    wa;
    t_slot            wd;
    logic             refuse;

    always_comb begin
        len_c = (i_req.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_req.key_length;
        for (int i = 0; i < 8; i++) begin
            key_m[8*i +: 8] = (4'(i) < len_c) ? i_req.key_bytes[8*i +: 8] : 8'h00;
        end
    end

    // one byte of the hash per step, quotient estimated by reciprocal
    assign dx    = {r_rem, r_h[63:56]};
    assign dprod = (XW+QW)'(dx) * (XW+QW)'(RECIP);
    assign dq    = dprod[XW+QW-1:XW];
    assign dqn   = (XW+QW)'(dq) * (XW+QW)'(TABLE_SLOTS);
    assign dr    = dx - dqn[XW-1:0];
    assign rem_n = (dr >= N_X) ? AW'(dr - N_X) : dr[AW-1:0];

    assign occ   = (r_rd.mark == MARK_OCCUPIED);
    assign match = occ && (r_rd.len == r_len) && (r_rd.key == r_key);

    assign o_sts.hash_done  = (r_bi == r_len);
    assign o_sts.mod_last   = IS_POW2 || (r_mbit == 6'd7);
    assign o_sts.probe_stop = (r_rd.mark == MARK_FREE) || match || (r_n == LAST);
    assign o_sts.clr_last   = (r_clr == LAST);

    assign refuse = !r_hit && ((r_cnt >= r_max_fill) || !r_ff_ok);

    always_comb begin
        we = 1'b0;
        wa = r_pos;
        wd = '{mark: MARK_OCCUPIED, len: r_len, key: r_key, value: r_val};
        if (i_cmd.clr_step) begin
            we      = 1'b1;
            wa      = r_clr;
            wd.mark = MARK_FREE;
        end else if (i_cmd.wr) begin
            case (r_action)
                ACT_INSERT: begin
                    if (r_hit) begin
                        we = 1'b1;
                    end else if (!refuse) begin
                        we = 1'b1;
                        wa = r_ff;
                    end
                end
                ACT_REMOVE: begin
                    we      = r_hit;
                    wd.mark = MARK_DELETED;
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (i_cmd.rd) r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_req.action;
            r_key    <= key_m;
            r_len    <= len_c;
            r_val    <= i_req.new_value;
            r_h      <= HASH_SEED;
            r_bi     <= '0;
            r_rem    <= '0;
            r_mbit   <= '0;
            r_n      <= '0;
            r_ff_ok  <= 1'b0;
            r_hit    <= 1'b0;
            r_found  <= '0;
        end
        if (i_cmd.hash_step) begin
            r_h  <= (r_h << 5) + r_h + {56'd0, r_key[8*r_bi[2:0] +: 8]};
            r_bi <= r_bi + 4'd1;
        end
        if (i_cmd.mod_step) begin
            if (IS_POW2) begin
                r_idx <= r_h[AW-1:0];
            end else begin
                r_h    <= r_h << 8;
                r_rem  <= rem_n;
                r_mbit <= r_mbit + 6'd1;
                r_idx  <= rem_n;
            end
        end
        if (i_cmd.chk) begin
            if (!occ && !r_ff_ok) begin
                r_ff_ok <= 1'b1;
                r_ff    <= r_idx;
            end
            if (match) begin
                r_hit   <= 1'b1;
                r_pos   <= r_idx;
                r_found <= r_rd.value;
            end
            r_n   <= r_n + 1'b1;
            r_idx <= (r_idx == LAST) ? '0 : r_idx + 1'b1;
        end
        if (i_cmd.wr) begin
            r_rsp.hit         <= r_hit;
            r_rsp.found_value <= r_found;
            r_rsp.status      <= (r_action == ACT_INSERT) && refuse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_max_fill <= MAX_FILL_RST;
            r_clr      <= '0;
            r_rsp_vld  <= 1'b0;
        end else begin
            r_rsp_vld <= i_cmd.wr;
            if (i_cfg_we) r_max_fill <= i_cfg_data;
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.wr) begin
                if (r_action == ACT_INSERT && !r_hit && !refuse) begin
                    r_cnt <= r_cnt + 1'b1;
                end else if (r_action == ACT_REMOVE && r_hit) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp     = r_rsp;
    assign o_rsp_vld = r_rsp_vld;

endmodule

/* tb/sv/tb_linear_probe_hash_table.sv */
// testbench of the linear probing hash table: directed and random requests checked against a table model
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 256;
    localparam int RUN_LIMIT = 400000;

    class lpht_scoreboard;
        t_mark       mark [SLOTS];
        logic [63:0] skey [SLOTS];
        logic [3:0]  slen [SLOTS];
        logic [31:0] sval [SLOTS];
        int unsigned fill;
        int unsigned fill_limit;
        t_rsp        pending [$];
        int          errors;

        function void clear();
            for (int i = 0; i < SLOTS; i++) begin
                mark[i] = MARK_FREE;
                skey[i] = '0;
                slen[i] = '0;
                sval[i] = '0;
            end
            fill = 0;
            fill_limit = MAX_FILL_RST;
            errors = 0;
        endfunction

        function void note_request(t_req r);
            logic [63:0] k;
            logic [63:0] h;
            int unsigned len;
            int unsigned home;
            int unsigned idx;
            int          pos;
            t_rsp        o;
            len = r.key_length;
            if (len > KEY_BYTES) len = KEY_BYTES;
            k = r.key_bytes;
            if (len < 8) k = k & ((64'd1 << (8 * len)) - 64'd1);
            h = HASH_SEED;
            for (int i = 0; i < len; i++) h = h * 64'd33 + 64'(k[8*i +: 8]);
            home = 32'(h % SLOTS);
            pos = -1;
            idx = home;
            for (int n = 0; n < SLOTS; n++) begin
                if (mark[idx] == MARK_FREE) break;
                if (mark[idx] == MARK_OCCUPIED && slen[idx] == len && skey[idx] == k) begin
                    pos = idx;
                    break;
                end
                idx = (idx + 1) % SLOTS;
            end
            o = '0;
            if (pos >= 0) begin
                o.hit = 1'b1;
                o.found_value = sval[pos];
            end
            if (r.action == ACT_INSERT) begin
                if (pos >= 0) begin
                    sval[pos] = r.new_value;
                end else if (fill >= fill_limit) begin
                    o.status = 1'b1;
                end else begin
                    o.status = 1'b1;
                    idx = home;
                    for (int n = 0; n < SLOTS; n++) begin
                        if (mark[idx] != MARK_OCCUPIED) begin
                            mark[idx] = MARK_OCCUPIED;
                            skey[idx] = k;
                            slen[idx] = 4'(len);
                            sval[idx] = r.new_value;
                            fill = (fill + 1) & 9'h1ff;
                            o.status = 1'b0;
                            break;
                        end
                        idx = (idx + 1) % SLOTS;
                    end
                end
            end else if (r.action == ACT_REMOVE && pos >= 0) begin
                mark[pos] = MARK_DELETED;
                fill = (fill - 1) & 9'h1ff;
            end
            pending.push_back(o);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit)
                $display("%0t: hit exp %b got %b", $realtime, want.hit, got.hit);
            if (got.found_value !== want.found_value)
                $display("%0t: found_value exp %h got %h", $realtime,
                         want.found_value, got.found_value);
            if (got.status !== want.status)
                $display("%0t: status exp %b got %b", $realtime, want.status, got.status);
            if (got !== want) errors++;
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_req             i_req = '0;
    logic             o_result_valid;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data = '0;

    lpht_scoreboard table_model = new();
    logic [63:0]    key_pool [16];
    logic [3:0]     len_pool [16];
    int unsigned    cycles = 0;

    linear_probe_hash_table #(.TABLE_SLOTS(SLOTS)) i_dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_result_valid) table_model.check_result(o_rsp);
        if (cycles > RUN_LIMIT) begin
            $display("[linear_probe_hash_table] ERROR");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] act, logic [63:0] k, logic [3:0] len,
                                logic [31:0] v);
        t_req r;
        int   gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap + 1) @(negedge i_clk);
        r.action = act;
        r.key_bytes = k;
        r.key_length = len;
        r.new_value = v;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        table_model.note_request(r);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic drain();
        while (table_model.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_fill_limit(logic [CNT_W-1:0] val);
        drain();
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        table_model.fill_limit = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count, int pool_used);
        int          p;
        logic [1:0]  act;
        logic [63:0] k;
        logic [3:0]  len;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(0, pool_used - 1);
            k = key_pool[p];
            len = len_pool[p];
            if ($urandom_range(0, 9) == 0) begin
                k = {$urandom, $urandom};
                len = 4'($urandom_range(0, 15));
            end
            act = $urandom_range(0, 9) < 5 ? ACT_INSERT : 2'($urandom_range(0, 3));
            send_request(act, k, len, $urandom);
        end
    endtask

    initial begin
        table_model.clear();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 16; i++) begin
            key_pool[i] = {$urandom, $urandom};
            len_pool[i] = 4'($urandom_range(0, 8));
        end
        len_pool[0] = 4'd8;
        send_request(ACT_LOOKUP, 64'h0, 4'd0, 32'h0);
        send_request(ACT_INSERT, 64'h0, 4'd0, 32'h7fffffff);
        send_request(ACT_LOOKUP, 64'hffff_ffff_ffff_ffff, 4'd0, 32'h0);
        send_request(ACT_INSERT, 64'hffff_ffff_ffff_ffff, 4'd15, 32'h80000000);
        send_request(ACT_LOOKUP, 64'hffff_ffff_ffff_ffff, 4'd8, 32'h0);
        send_request(ACT_INSERT, 64'hffff_ffff_ffff_ffff, 4'd9, 32'hffffffff);
        send_request(ACT_INSERT, 64'h0000_0000_0000_0041, 4'd1, 32'h1);
        send_request(ACT_LOOKUP, 64'hffff_ffff_ffff_ff41, 4'd1, 32'h0);
        send_request(2'd3, 64'h0000_0000_0000_0041, 4'd1, 32'h0);
        send_request(ACT_REMOVE, 64'h41, 4'd1, 32'h0);
        send_request(ACT_REMOVE, 64'h41, 4'd1, 32'h0);
        send_request(ACT_LOOKUP, 64'h41, 4'd1, 32'h0);
        send_request(ACT_INSERT, 64'h42, 4'd1, 32'h5555aaaa);
        send_request(ACT_REMOVE, 64'h0, 4'd0, 32'h0);
        write_fill_limit(9'd0);
        send_request(ACT_INSERT, 64'h1234, 4'd2, 32'h1);
        send_request(ACT_INSERT, 64'h42, 4'd1, 32'h2);
        write_fill_limit(9'd1);
        send_request(ACT_INSERT, 64'h99, 4'd1, 32'h3);
        write_fill_limit(9'd4);
        random_phase(100, 16);
        write_fill_limit(9'd256);
        for (int i = 0; i < 16; i++) begin
            key_pool[i] = {$urandom, $urandom};
            len_pool[i] = 4'($urandom_range(1, 8));
        end
        random_phase(100, 16);
        write_fill_limit(9'd511);
        random_phase(100, 16);
        write_fill_limit(9'd192);
        random_phase(100, 16);
        drain();
        if (table_model.errors == 0 && table_model.pending.size() == 0) begin
            $display("[linear_probe_hash_table] OK");
        end else begin
            $display("[linear_probe_hash_table] ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/lpht_pkg.sv
rtl/core/lpht_ctrl.sv
rtl/core/lpht_dp.sv
rtl/core/linear_probe_hash_table.sv
tb/sv/tb_linear_probe_hash_table.sv
